// ===== hdl/tdpt_pkg.sv =====
// Shared types and constants for the trial division prime test.
package tdpt_pkg;

   // Default candidate width in bits.
   localparam int DefaultWidth = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;       // capture the candidate, set the first divisor
      logic start_div;      // clear the remainder and arm the bit counter
      logic step_div;       // one restoring remainder step
      logic next_divisor;   // move to the next odd divisor
      logic set_verdict;    // write verdict_value into the verdict register
      logic verdict_value;  // 1 for prime, 0 for not prime
      logic load_rsp;       // copy the verdict into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic lt_two;         // candidate below two
      logic is_two;         // candidate equals two
      logic is_even;        // candidate is even
      logic sq_gt_n;        // divisor squared exceeds the candidate
      logic div_last;       // the current remainder step is the last one
      logic rem_zero;       // remainder after the current step is zero
   } status_type;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_CLASSIFY = 5'b00010,
      ST_TEST     = 5'b00100,
      ST_DIVIDE   = 5'b01000,
      ST_DONE     = 5'b10000
   } state_type;

endpackage

// ===== hdl/tdpt_ctrl.sv =====
// Controller state machine for the trial division prime test.
module tdpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);

   tdpt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   // A request is taken only when no test is in progress.
   assign req_stall = (state_ff != tdpt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The response register can take a new verdict when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = tdpt_pkg::ST_CLASSIFY;
            end
         end
         tdpt_pkg::ST_CLASSIFY: begin
            // Small and even values are settled without any division.
            if (status.lt_two) begin
               cmd.set_verdict   = 1'b1;
               cmd.verdict_value = 1'b0;
               state_in          = tdpt_pkg::ST_DONE;
            end else if (status.is_two) begin
               cmd.set_verdict   = 1'b1;
               cmd.verdict_value = 1'b1;
               state_in          = tdpt_pkg::ST_DONE;
            end else if (status.is_even) begin
               cmd.set_verdict   = 1'b1;
               cmd.verdict_value = 1'b0;
               state_in          = tdpt_pkg::ST_DONE;
            end else begin
               state_in = tdpt_pkg::ST_TEST;
            end
         end
         tdpt_pkg::ST_TEST: begin
            // Once the divisor passes the square root, no factor remains.
            if (status.sq_gt_n) begin
               cmd.set_verdict   = 1'b1;
               cmd.verdict_value = 1'b1;
               state_in          = tdpt_pkg::ST_DONE;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            cmd.step_div = 1'b1;
            if (status.div_last) begin
               if (status.rem_zero) begin
                  cmd.set_verdict   = 1'b1;
                  cmd.verdict_value = 1'b0;
                  state_in          = tdpt_pkg::ST_DONE;
               end else begin
                  cmd.next_divisor = 1'b1;
                  state_in         = tdpt_pkg::ST_TEST;
               end
            end
         end
         tdpt_pkg::ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   // Response valid: set on a new verdict, cleared when the response is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/tdpt_dpath.sv =====
// Datapath for the trial division prime test: divisor, square and serial remainder.
module tdpt_dpath #(
   parameter int WIDTH = tdpt_pkg::DefaultWidth
) (
   input  logic                 clock,
   input  logic [WIDTH-1:0]     req_candidate,
   output logic                 rsp_prime_flag,
   input  tdpt_pkg::cmd_type    cmd,
   output tdpt_pkg::status_type status
);

   localparam int CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int SqW  = WIDTH + 3;

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [SqW-1:0]   sq_ff, sq_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             verdict_ff, verdict_in;
   logic             flag_ff, flag_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   d_ext;
   logic             trial_ge;
   logic [WIDTH-1:0] r_step;

   // One restoring step: bring in the next candidate bit, subtract if it fits.
   assign trial    = {r_ff, shift_ff[WIDTH-1]};
   assign d_ext    = {1'b0, d_ff};
   assign trial_ge = (trial >= d_ext);
   assign r_step   = trial_ge ? WIDTH'(trial - d_ext) : trial[WIDTH-1:0];

   // Status toward the controller.
   always_comb begin
      status          = '0;
      status.lt_two   = (n_ff < WIDTH'(2));
      status.is_two   = (n_ff == WIDTH'(2));
      status.is_even  = !n_ff[0];
      status.sq_gt_n  = (sq_ff > {3'b000, n_ff});
      status.div_last = (cnt_ff == '0);
      status.rem_zero = (r_step == '0);
   end

   // Register updates under controller commands.
   always_comb begin
      n_in       = n_ff;
      d_in       = d_ff;
      sq_in      = sq_ff;
      r_in       = r_ff;
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      verdict_in = verdict_ff;
      flag_in    = flag_ff;
      if (cmd.load_req) begin
         n_in  = req_candidate;
         d_in  = WIDTH'(3);
         sq_in = SqW'(9);
      end
      if (cmd.start_div) begin
         r_in     = '0;
         shift_in = n_ff;
         cnt_in   = CntW'(WIDTH - 1);
      end
      if (cmd.step_div) begin
         r_in     = r_step;
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff - CntW'(1);
      end
      // (d + 2)^2 = d^2 + 4d + 4.
      if (cmd.next_divisor) begin
         d_in  = d_ff + WIDTH'(2);
         sq_in = sq_ff + {1'b0, d_ff, 2'b00} + SqW'(4);
      end
      if (cmd.set_verdict) begin
         verdict_in = cmd.verdict_value;
      end
      if (cmd.load_rsp) begin
         flag_in = verdict_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      d_ff       <= d_in;
      sq_ff      <= sq_in;
      r_ff       <= r_in;
      shift_ff   <= shift_in;
      cnt_ff     <= cnt_in;
      verdict_ff <= verdict_in;
      flag_ff    <= flag_in;
   end

   assign rsp_prime_flag = flag_ff;

endmodule

// ===== hdl/trial_division_prime_test.sv =====
// Values below two, two and even values are settled in the classify state without any division.
// Odd values try odd divisors in turn until one divides or the divisor squared exceeds the value.
// Each divisor costs one square compare plus a serial remainder pass over all WIDTH candidate bits.
// One request is worked at a time; the next is taken in the cycle after the response is loaded.
// Reset (synchronous, active high) returns the controller to idle and empties the response.
// Top level of the trial division prime test.
module trial_division_prime_test #(
   parameter int WIDTH = tdpt_pkg::DefaultWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_candidate,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_prime_flag
);

   tdpt_pkg::cmd_type    cmd;
   tdpt_pkg::status_type status;

   // Sequencing of one request.
   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Divisor, square and remainder arithmetic.
   tdpt_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock          (clock),
      .req_candidate  (req_candidate),
      .rsp_prime_flag (rsp_prime_flag),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// ===== hdl/tdpt_checker.sv =====
// Port-level assertions for the trial division prime test, bound to the top level.
module tdpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_prime_flag
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prime_flag))
      else $error("stalled response changed");

   // After a request is taken the block stays busy through the classify state and the state after it.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("request taken while a test was in progress");

   // A new response appears only at the end of a test.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a test in progress");

   // Reset leaves the block idle with no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind trial_division_prime_test tdpt_checker u_checker (.*);

// ===== bench/trial_division_prime_test_test.sv =====
// Self-checking testbench for the trial division prime test block.
module trial_division_prime_test_test;

   localparam int CandWidth = tdpt_pkg::DefaultWidth;
   // Longest legal quiet stretch: one large odd candidate plus idling, several times over.
   localparam int QuietLimit = 300000;
   localparam int RandomCount = 76;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CandWidth-1:0] req_candidate;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_prime_flag;

   logic [CandWidth-1:0] candidate_q[$];
   bit                   verdict_q[$];
   int                   mismatch_count;
   int                   quiet_cycles;

   // Request side idling.
   bit req_busy;
   bit req_taken;
   bit req_burst;
   int req_gap;

   // Response side idling.
   bit rsp_taken;
   bit rsp_burst;
   int rsp_hold;

   trial_division_prime_test #(
      .WIDTH(CandWidth)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_candidate(req_candidate),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime_flag(rsp_prime_flag)
   );

   // Primality by trial division over odd divisors up to the square root.
   function automatic bit prime_verdict(logic [CandWidth-1:0] value);
      longint unsigned n;
      longint unsigned d;
      n = longint'(value);
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record the verdict of every request the block accepts.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         verdict_q.push_back(prime_verdict(req_candidate));
         req_taken = 1'b1;
      end
   end

   // Present requests from the pending queue, with random gaps between them.
   always @(negedge clock) begin
      bit next_valid;
      next_valid = 1'b0;
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy = 1'b0;
            if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 13);
         end
         if (req_busy) begin
            next_valid = 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
         end else if (candidate_q.size() > 0) begin
            req_candidate <= candidate_q.pop_front();
            req_busy = 1'b1;
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // Compare each accepted response with the oldest expected verdict.
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         if (verdict_q.size() == 0) begin
            $display("%0t: response with no request outstanding, prime_flag %0b",
                     $time, rsp_prime_flag);
            mismatch_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_prime_flag !== want) begin
               $display("%0t: prime_flag expected %0b, actual %0b",
                        $time, want, rsp_prime_flag);
               mismatch_count++;
            end
         end
      end
   end

   // Stall the response side for a random number of cycles after each response.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 13);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Build the request list, run reset, then wait for every verdict.
   initial begin
      int unsigned pick;
      int unsigned factor;
      int unsigned span;
      int unsigned odd_primes[5];
      logic [CandWidth-1:0] value;

      odd_primes = '{3, 5, 7, 11, 13};
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate = '0;
      rsp_stall = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      req_busy = 1'b0;
      req_taken = 1'b0;
      req_burst = 1'b0;
      req_gap = 0;
      rsp_taken = 1'b0;
      rsp_burst = 1'b0;
      rsp_hold = 0;

      // Zero, one, two, small odd primes, squares of primes and field extremes.
      candidate_q = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 121, 169, 961, 97,
                      65521, 65535, 1048573, 16777213,
                      32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000, 32'hFFFFFFF9,
                      32'hAAAAAAAA, 32'h55555555};

      // Mostly small values, with some wide values that still resolve quickly.
      for (int i = 0; i < RandomCount; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            value = $urandom_range(0, 65535);
         end else if (pick < 60) begin
            value = $urandom_range(0, 1048575);
         end else if (pick < 75) begin
            // Wide even value.
            value = $urandom;
            value[0] = 1'b0;
         end else if (pick < 90) begin
            // Wide multiple of a small odd prime, so a divisor is found early.
            factor = odd_primes[$urandom_range(0, 4)];
            span = 32'hFFFFFFFF / factor;
            value = factor * ($urandom % span);
         end else begin
            value = $urandom_range(0, 3);
         end
         candidate_q.push_back(value);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (candidate_q.size() > 0 || req_busy || verdict_q.size() > 0) begin
         @(negedge clock);
      end
      repeat (40) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
